// ===== sv/csrdsp_pkg.sv =====
// Shared types and codes for the CSR shortest path core.
package csrdsp_pkg;

    typedef enum logic [1:0] {
        REQ_ROW   = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_START = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_OBJECTIVE  = 2'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QWAIT,
        ST_CLR,
        ST_INIT,
        ST_POP,
        ST_POPW,
        ST_SRD,
        ST_SCMP,
        ST_VISIT,
        ST_VCHK,
        ST_EDGE,
        ST_ERD,
        ST_ECMP,
        ST_PUSH,
        ST_PRD,
        ST_PCMP
    } state_t;

    localparam int DIST_W  = 48;
    localparam int COST_W  = 31;
    localparam int ROW_W   = 13;
    localparam int TGT_W   = 10;
    localparam int PAR_W   = 11;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 64;

endpackage

// ===== sv/csr_dijkstra_shortest_path_core.sv =====
// Top level of the CSR shortest path core: loads, search sequencer, queries.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tuser req_type, s_tdata load/start/query fields
//  m_axis    out  m_tvalid/m_tready    m_tdata status, done, reach, distance, parent
//  cfg       in   cfg_we               cfg_addr index, cfg_wdata value
//
// A load in range writes its memory when accepted; a query reads the node memory first.
// A start clears every node memory entry, then runs the search: a heap pop reads
// the root and last entries and sifts down level by level, a visit reads the node
// and row entries, each edge reads its target and cost and, if the target is in
// range, its node entry, and a push sifts up level by level.
// Input stalls while a query or search runs or a result waits.
module csr_dijkstra_shortest_path_core #(
    parameter int MAX_NODES      = 1024,
    parameter int MAX_EDGES      = 4096,
    parameter int NUM_OBJECTIVES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[12:0], row_start[25:13], target_node[35:26], edge_weight[66:36],
    // weight_objective[68:67], source_node[78:69]
    input  logic [79:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], search_done[1], node_reachable[2], node_distance[50:3],
    // parent_node[61:51]
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    localparam int NA_W  = $clog2(MAX_NODES);
    localparam int RA_W  = $clog2(MAX_NODES + 1);
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int OB_W  = (NUM_OBJECTIVES > 1) ? $clog2(NUM_OBJECTIVES) : 1;
    localparam int CA_W  = $clog2(MAX_EDGES * NUM_OBJECTIVES);
    localparam int HEAP_DEPTH = MAX_EDGES + 1;
    localparam int HA_W  = $clog2(HEAP_DEPTH);
    localparam int HF_W  = $clog2(HEAP_DEPTH + 1);
    localparam int KEY_W = csrdsp_pkg::DIST_W + NA_W;
    localparam int NE_W  = 1 + csrdsp_pkg::DIST_W + 1 + NA_W;

    // node entry: {inf, dist, parent valid, parent id}
    logic [NE_W-1:0]                node_mem [MAX_NODES];
    logic [csrdsp_pkg::ROW_W-1:0]   row_mem  [MAX_NODES+1];
    logic [csrdsp_pkg::TGT_W-1:0]   tgt_mem  [MAX_EDGES];
    logic [csrdsp_pkg::COST_W-1:0]  cost_mem [MAX_EDGES*NUM_OBJECTIVES];
    logic [KEY_W-1:0]               heap_mem [HEAP_DEPTH];

    csrdsp_pkg::state_t state_reg, state_next;

    logic [10:0]                   node_count_reg;
    logic [1:0]                    obj_reg;
    logic                          searched_reg, searched_next;
    logic [HF_W-1:0]               fill_reg, fill_next;
    logic [HA_W-1:0]               hi_reg, hi_next;
    logic [NA_W-1:0]               clr_reg, clr_next;
    logic [NA_W-1:0]               src_reg, src_next;
    logic [KEY_W-1:0]              top_reg, top_next;
    logic [KEY_W-1:0]              last_reg, last_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [csrdsp_pkg::ROW_W-1:0]  e_reg, e_next;
    logic [csrdsp_pkg::ROW_W:0]    ehi_reg, ehi_next;
    logic [NA_W-1:0]               v_reg, v_next;
    logic [csrdsp_pkg::DIST_W-1:0] cand_reg, cand_next;
    logic                          qok_reg, qok_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    logic                  node_we;
    logic [NA_W-1:0]       node_waddr, node_raddr;
    logic [NE_W-1:0]       node_wdata, node_rd;
    logic                  heap_we;
    logic [HA_W-1:0]       heap_waddr, heap_ra0, heap_ra1;
    logic [KEY_W-1:0]      heap_wdata, heap_rd0, heap_rd1;
    logic [RA_W-1:0]       row_ra0, row_ra1;
    logic [csrdsp_pkg::ROW_W-1:0] row_rd0, row_rd1;
    logic [EA_W-1:0]       tgt_ra;
    logic [csrdsp_pkg::TGT_W-1:0] tgt_rd;
    logic [CA_W-1:0]       cost_ra;
    logic [csrdsp_pkg::COST_W-1:0] cost_rd;

    logic [NC_W-1:0] n_eff;
    logic            in_acc;
    logic [12:0]     in_slot, in_row;
    logic [9:0]      in_tgt, in_src;
    logic [30:0]     in_w;
    logic [1:0]      in_obj;
    logic [OB_W-1:0] obj_sel, ld_obj;

    assign in_slot = s_tdata[12:0];
    assign in_row  = s_tdata[25:13];
    assign in_tgt  = s_tdata[35:26];
    assign in_w    = s_tdata[66:36];
    assign in_obj  = s_tdata[68:67];
    assign in_src  = s_tdata[78:69];

    assign n_eff   = (32'(node_count_reg) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES)
                                                            : NC_W'(node_count_reg);
    assign obj_sel = OB_W'(32'(obj_reg) % NUM_OBJECTIVES);
    assign ld_obj  = OB_W'(32'(in_obj) % NUM_OBJECTIVES);

    assign s_tready = (state_reg == csrdsp_pkg::ST_IDLE) && !(out_valid_reg && !m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // load writes and read ports
    always_ff @(posedge clk)
    begin
        if (in_acc && (s_tuser == csrdsp_pkg::REQ_ROW) && (32'(in_slot) <= 32'(MAX_NODES)))
        begin
            row_mem[RA_W'(in_slot)] <= in_row;
        end
        if (in_acc && (s_tuser == csrdsp_pkg::REQ_EDGE) && (32'(in_slot) < 32'(MAX_EDGES)))
        begin
            tgt_mem[EA_W'(in_slot)] <= in_tgt;
            cost_mem[CA_W'(32'(in_slot) * NUM_OBJECTIVES + 32'(ld_obj))] <= in_w;
        end
        row_rd0 <= row_mem[row_ra0];
        row_rd1 <= row_mem[row_ra1];
        tgt_rd  <= tgt_mem[tgt_ra];
        cost_rd <= cost_mem[cost_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd0 <= heap_mem[heap_ra0];
        heap_rd1 <= heap_mem[heap_ra1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 11'd1;
            obj_reg        <= 2'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == csrdsp_pkg::CFG_NODE_COUNT)
            begin
                node_count_reg <= cfg_wdata;
            end
            else if (cfg_addr == csrdsp_pkg::CFG_OBJECTIVE)
            begin
                obj_reg <= cfg_wdata[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csrdsp_pkg::ST_IDLE;
            searched_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            searched_reg  <= searched_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= hi_next;
        clr_reg      <= clr_next;
        src_reg      <= src_next;
        top_reg      <= top_next;
        last_reg     <= last_next;
        key_reg      <= key_next;
        e_reg        <= e_next;
        ehi_reg      <= ehi_next;
        v_reg        <= v_next;
        cand_reg     <= cand_next;
        qok_reg      <= qok_next;
        out_data_reg <= out_data_next;
    end

    logic [NA_W-1:0]               top_u;
    logic [csrdsp_pkg::DIST_W-1:0] top_d;
    logic [HA_W+1:0]               child;
    logic [KEY_W-1:0]              pick;
    logic [HA_W-1:0]               pick_idx;
    logic [csrdsp_pkg::DIST_W-1:0] nd_dist;
    logic                          nd_inf, nd_pv;
    logic [NA_W-1:0]               nd_pid;
    logic [HA_W-1:0]               par_idx;

    assign top_u   = top_reg[NA_W-1:0];
    assign top_d   = top_reg[KEY_W-1:NA_W];
    assign child   = (HA_W+2)'({hi_reg, 1'b1});
    assign nd_inf  = node_rd[NE_W-1];
    assign nd_dist = node_rd[NE_W-2 -: csrdsp_pkg::DIST_W];
    assign nd_pv   = node_rd[NA_W];
    assign nd_pid  = node_rd[NA_W-1:0];
    assign par_idx = HA_W'((hi_reg - HA_W'(1)) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        searched_next  = searched_reg;
        fill_next      = fill_reg;
        hi_next        = hi_reg;
        clr_next       = clr_reg;
        src_next       = src_reg;
        top_next       = top_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        e_next         = e_reg;
        ehi_next       = ehi_reg;
        v_next         = v_reg;
        cand_next      = cand_reg;
        qok_next       = qok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        node_we        = 1'b0;
        node_waddr     = '0;
        node_wdata     = '0;
        node_raddr     = '0;
        heap_we        = 1'b0;
        heap_waddr     = '0;
        heap_wdata     = '0;
        heap_ra0       = '0;
        heap_ra1       = '0;
        row_ra0        = '0;
        row_ra1        = '0;
        tgt_ra         = EA_W'(e_reg);
        cost_ra        = CA_W'(32'(e_reg) * NUM_OBJECTIVES + 32'(obj_sel));
        pick           = heap_rd0;
        pick_idx       = HA_W'(child);

        unique case (state_reg)
            csrdsp_pkg::ST_IDLE:
            begin
                if (in_acc && (s_tuser == csrdsp_pkg::REQ_QUERY))
                begin
                    node_raddr = NA_W'(in_slot);
                    qok_next   = searched_reg && (32'(in_slot) < 32'(n_eff));
                    state_next = csrdsp_pkg::ST_QWAIT;
                end
                else if (in_acc && (s_tuser == csrdsp_pkg::REQ_START))
                begin
                    src_next      = NA_W'(in_src);
                    // bit 0 flags a source outside the node count
                    ehi_next      = (32'(in_src) < 32'(n_eff)) ? 14'd0 : 14'd1;
                    clr_next      = '0;
                    searched_next = 1'b1;
                    fill_next     = '0;
                    state_next    = csrdsp_pkg::ST_CLR;
                end
            end
            csrdsp_pkg::ST_QWAIT:
            begin
                out_valid_next = 1'b1;
                if (qok_reg && !nd_inf)
                begin
                    out_data_next = {2'b00,
                                     nd_pv ? 11'(nd_pid) : 11'h7FF,
                                     nd_dist, 1'b1, 2'b00};
                end
                else
                begin
                    out_data_next = {2'b00, 11'h7FF, 48'd0, 3'b000};
                end
                state_next = csrdsp_pkg::ST_IDLE;
            end
            csrdsp_pkg::ST_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = {1'b1, {(NE_W-1){1'b0}}};
                clr_next   = clr_reg + NA_W'(1);
                if (clr_reg == NA_W'(MAX_NODES - 1))
                begin
                    if (ehi_reg[0])
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {2'b00, 11'h7FF, 48'd0, 3'b011};
                        state_next     = csrdsp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = csrdsp_pkg::ST_INIT;
                    end
                end
            end
            csrdsp_pkg::ST_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = src_reg;
                node_wdata = '0;
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = {{csrdsp_pkg::DIST_W{1'b0}}, src_reg};
                fill_next  = HF_W'(1);
                state_next = csrdsp_pkg::ST_POP;
            end
            csrdsp_pkg::ST_POP:
            begin
                if (fill_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, 11'h7FF, 48'd0, 3'b010};
                    state_next     = csrdsp_pkg::ST_IDLE;
                end
                else
                begin
                    heap_ra0   = '0;
                    heap_ra1   = HA_W'(fill_reg - HF_W'(1));
                    fill_next  = fill_reg - HF_W'(1);
                    state_next = csrdsp_pkg::ST_POPW;
                end
            end
            csrdsp_pkg::ST_POPW:
            begin
                top_next  = heap_rd0;
                last_next = heap_rd1;
                hi_next   = '0;
                state_next = (fill_reg == '0) ? csrdsp_pkg::ST_VISIT : csrdsp_pkg::ST_SRD;
            end
            csrdsp_pkg::ST_SRD:
            begin
                if (32'(child) >= 32'(fill_reg))
                begin
                    heap_we    = 1'b1;
                    heap_waddr = hi_reg;
                    heap_wdata = last_reg;
                    state_next = csrdsp_pkg::ST_VISIT;
                end
                else
                begin
                    heap_ra0   = HA_W'(child);
                    heap_ra1   = HA_W'(child + (HA_W+2)'(1));
                    state_next = csrdsp_pkg::ST_SCMP;
                end
            end
            csrdsp_pkg::ST_SCMP:
            begin
                if ((32'(child) + 1 < 32'(fill_reg)) && (heap_rd1 < heap_rd0))
                begin
                    pick     = heap_rd1;
                    pick_idx = HA_W'(child + (HA_W+2)'(1));
                end
                heap_we    = 1'b1;
                heap_waddr = hi_reg;
                if (last_reg <= pick)
                begin
                    heap_wdata = last_reg;
                    state_next = csrdsp_pkg::ST_VISIT;
                end
                else
                begin
                    heap_wdata = pick;
                    hi_next    = pick_idx;
                    state_next = csrdsp_pkg::ST_SRD;
                end
            end
            csrdsp_pkg::ST_VISIT:
            begin
                if (32'(top_u) >= 32'(n_eff))
                begin
                    state_next = csrdsp_pkg::ST_POP;
                end
                else
                begin
                    node_raddr = top_u;
                    row_ra0    = RA_W'(top_u);
                    row_ra1    = RA_W'(32'(top_u) + 1);
                    state_next = csrdsp_pkg::ST_VCHK;
                end
            end
            csrdsp_pkg::ST_VCHK:
            begin
                if (nd_inf || (nd_dist != top_d))
                begin
                    state_next = csrdsp_pkg::ST_POP;
                end
                else
                begin
                    e_next     = row_rd0;
                    ehi_next   = (32'(row_rd1) > 32'(MAX_EDGES)) ? 14'(MAX_EDGES)
                                                                 : {1'b0, row_rd1};
                    state_next = csrdsp_pkg::ST_EDGE;
                end
            end
            csrdsp_pkg::ST_EDGE:
            begin
                state_next = ({1'b0, e_reg} >= ehi_reg) ? csrdsp_pkg::ST_POP
                                                        : csrdsp_pkg::ST_ERD;
            end
            csrdsp_pkg::ST_ERD:
            begin
                if (32'(tgt_rd) >= 32'(n_eff))
                begin
                    e_next     = e_reg + 13'd1;
                    state_next = csrdsp_pkg::ST_EDGE;
                end
                else
                begin
                    node_raddr = NA_W'(tgt_rd);
                    v_next     = NA_W'(tgt_rd);
                    cand_next  = top_d + csrdsp_pkg::DIST_W'(cost_rd);
                    state_next = csrdsp_pkg::ST_ECMP;
                end
            end
            csrdsp_pkg::ST_ECMP:
            begin
                node_waddr = v_reg;
                if (nd_inf || (cand_reg < nd_dist))
                begin
                    node_we    = 1'b1;
                    node_wdata = {1'b0, cand_reg, 1'b1, top_u};
                    key_next   = {cand_reg, v_reg};
                    state_next = csrdsp_pkg::ST_PUSH;
                end
                else
                begin
                    if ((cand_reg == nd_dist) && (v_reg != src_reg) && nd_pv
                        && (top_u < nd_pid))
                    begin
                        node_we    = 1'b1;
                        node_wdata = {1'b0, nd_dist, 1'b1, top_u};
                    end
                    e_next     = e_reg + 13'd1;
                    state_next = csrdsp_pkg::ST_EDGE;
                end
            end
            csrdsp_pkg::ST_PUSH:
            begin
                if (32'(fill_reg) >= HEAP_DEPTH)
                begin
                    e_next     = e_reg + 13'd1;
                    state_next = csrdsp_pkg::ST_EDGE;
                end
                else
                begin
                    hi_next    = HA_W'(fill_reg);
                    fill_next  = fill_reg + HF_W'(1);
                    state_next = csrdsp_pkg::ST_PRD;
                end
            end
            csrdsp_pkg::ST_PRD:
            begin
                if (hi_reg == '0)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    heap_wdata = key_reg;
                    e_next     = e_reg + 13'd1;
                    state_next = csrdsp_pkg::ST_EDGE;
                end
                else
                begin
                    heap_ra0   = par_idx;
                    state_next = csrdsp_pkg::ST_PCMP;
                end
            end
            csrdsp_pkg::ST_PCMP:
            begin
                heap_we    = 1'b1;
                heap_waddr = hi_reg;
                if (heap_rd0 <= key_reg)
                begin
                    heap_wdata = key_reg;
                    e_next     = e_reg + 13'd1;
                    state_next = csrdsp_pkg::ST_EDGE;
                end
                else
                begin
                    heap_wdata = heap_rd0;
                    hi_next    = par_idx;
                    state_next = csrdsp_pkg::ST_PRD;
                end
            end
            default:
            begin
                state_next = csrdsp_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= HEAP_DEPTH)
        else $error("heap fill beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == csrdsp_pkg::ST_IDLE))
        else $error("input ready while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csrdsp_pkg::ST_ECMP) |-> !out_valid_reg)
        else $error("result pending during search");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the CSR shortest path core: random graphs, searches and queries.
`timescale 1ns / 100ps

module tb_top;

    localparam int NODES_MAX  = 1024;
    localparam int EDGES_MAX  = 4096;
    localparam int OBJ_NUM    = 4;
    localparam int HEAP_SIZE  = EDGES_MAX + 1;
    localparam int LIMIT      = 3000000;
    localparam int DRAIN      = 40;
    localparam logic [63:0] DIST_INF = 64'd1 << 48;

    typedef struct {
        csrdsp_pkg::req_t req;
        bit [12:0]   slot;
        bit [12:0]   row_start;
        bit [9:0]    target;
        bit [30:0]   weight;
        bit [1:0]    objective;
        bit [9:0]    source;
    } beat_t;

    typedef struct {
        bit          status;
        bit          done;
        bit          reach;
        bit [47:0]   distance;
        bit [10:0]   parent;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [10:0] cfg_wdata;

    csr_dijkstra_shortest_path_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    bit [10:0]  node_cnt_reg;
    bit [1:0]   obj_sel_reg;
    bit [12:0]  row_mem [0:NODES_MAX];
    bit [9:0]   tgt_mem [0:EDGES_MAX-1];
    bit [30:0]  cost_mem [0:EDGES_MAX*OBJ_NUM-1];
    bit [48:0]  best_dist [0:NODES_MAX-1];
    int         tree_par [0:NODES_MAX-1];
    bit [63:0]  frontier [0:HEAP_SIZE-1];
    int         frontier_fill;

    // stimulus bookkeeping
    bit         row_written [0:NODES_MAX];
    int         edge_top;
    int         item_total;

    beat_t      pending_beats[$];
    answer_t    expected_answers[$];
    beat_t      cur_beat;
    int         src_gap;
    int         snk_gap;
    bit         src_quiet;
    bit         snk_quiet;
    int         mismatches;
    int         cycles;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int nodes_in_use();
        return (node_cnt_reg > NODES_MAX) ? NODES_MAX : int'(node_cnt_reg);
    endfunction

    function automatic void frontier_push(bit [63:0] key);
        int i;
        int p;
        if (frontier_fill >= HEAP_SIZE)
            return;
        i = frontier_fill;
        frontier_fill++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (frontier[p] <= key)
                break;
            frontier[i] = frontier[p];
            i = p;
        end
        frontier[i] = key;
    endfunction

    function automatic bit [63:0] frontier_pop();
        bit [63:0] top;
        bit [63:0] last;
        int i;
        int c;
        top = frontier[0];
        i = 0;
        frontier_fill--;
        if (frontier_fill == 0)
            return top;
        last = frontier[frontier_fill];
        forever
        begin
            c = 2 * i + 1;
            if (c >= frontier_fill)
                break;
            if (c + 1 < frontier_fill && frontier[c + 1] < frontier[c])
                c++;
            if (last <= frontier[c])
                break;
            frontier[i] = frontier[c];
            i = c;
        end
        frontier[i] = last;
        return top;
    endfunction

    function automatic bit shortest_paths(bit [9:0] src);
        int n;
        int u;
        int v;
        int lo;
        int hi;
        int e;
        bit [63:0] key;
        bit [63:0] d;
        bit [63:0] cand;
        n = nodes_in_use();
        for (int i = 0; i < NODES_MAX; i++)
        begin
            best_dist[i] = DIST_INF[48:0];
            tree_par[i] = -1;
        end
        frontier_fill = 0;
        if (int'(src) >= n)
            return 1'b1;
        best_dist[src] = '0;
        frontier_push(64'(src));
        while (frontier_fill > 0)
        begin
            key = frontier_pop();
            u = int'(key[16:0]);
            d = key >> 17;
            if (u >= n || d != 64'(best_dist[u]))
                continue;
            lo = row_mem[u];
            hi = row_mem[u + 1];
            if (hi > EDGES_MAX)
                hi = EDGES_MAX;
            for (e = lo; e < hi; e++)
            begin
                v = tgt_mem[e];
                if (v >= n)
                    continue;
                cand = d + 64'(cost_mem[e * OBJ_NUM + obj_sel_reg]);
                if (cand < 64'(best_dist[v]))
                begin
                    best_dist[v] = cand[48:0];
                    tree_par[v] = u;
                    frontier_push((cand << 17) | 64'(v));
                end
                else if (cand == 64'(best_dist[v]) && v != int'(src) && u < tree_par[v])
                    tree_par[v] = u;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_beat(beat_t b);
        answer_t a;
        a = '{status: 1'b0, done: 1'b0, reach: 1'b0, distance: '0, parent: '1};
        case (b.req)
            csrdsp_pkg::REQ_ROW:
                if (b.slot <= NODES_MAX)
                    row_mem[b.slot] = b.row_start;
            csrdsp_pkg::REQ_EDGE:
                if (b.slot < EDGES_MAX)
                begin
                    tgt_mem[b.slot] = b.target;
                    cost_mem[int'(b.slot) * OBJ_NUM + b.objective] = b.weight;
                end
            csrdsp_pkg::REQ_START:
            begin
                a.status = shortest_paths(b.source);
                a.done = 1'b1;
                expected_answers.push_back(a);
            end
            default:
            begin
                if (int'(b.slot) < nodes_in_use() && 64'(best_dist[b.slot]) < DIST_INF)
                begin
                    a.reach = 1'b1;
                    a.distance = best_dist[b.slot][47:0];
                    a.parent = tree_par[b.slot][10:0];
                end
                expected_answers.push_back(a);
            end
        endcase
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            src_gap = 0;
            src_quiet = 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
                predict_beat(cur_beat);
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                cur_beat = pending_beats.pop_front();
                s_tdata <= {1'b0, cur_beat.source, cur_beat.objective, cur_beat.weight,
                            cur_beat.target, cur_beat.row_start, cur_beat.slot};
                s_tuser <= cur_beat.req;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    src_quiet = !src_quiet;
                src_gap = draw_gap(src_quiet);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap = 0;
            snk_quiet = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tdata[0] !== want.status || m_tdata[1] !== want.done ||
                        m_tdata[2] !== want.reach || m_tdata[50:3] !== want.distance ||
                        m_tdata[61:51] !== want.parent)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d dn=%0d rc=%0d d=%0d p=%h",
                                      " | got st=%0d dn=%0d rc=%0d d=%0d p=%h"},
                                     want.status, want.done, want.reach, want.distance,
                                     want.parent, m_tdata[0], m_tdata[1], m_tdata[2],
                                     m_tdata[50:3], m_tdata[61:51]);
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    snk_quiet = !snk_quiet;
                snk_gap = draw_gap(snk_quiet);
            end
            else if (snk_gap > 0)
                snk_gap--;
            m_tready <= (snk_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_beats.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(csrdsp_pkg::cfg_idx_t idx, bit [10:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        if (idx == csrdsp_pkg::CFG_NODE_COUNT)
            node_cnt_reg = value;
        else
            obj_sel_reg = value[1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_beat(csrdsp_pkg::req_t req, int slot, int row_start, int target,
                            bit [30:0] weight, int objective, int source);
        beat_t b;
        b.req = req;
        b.slot = slot[12:0];
        b.row_start = row_start[12:0];
        b.target = target[9:0];
        b.weight = weight;
        b.objective = objective[1:0];
        b.source = source[9:0];
        pending_beats.push_back(b);
        item_total++;
    endtask

    function automatic bit [30:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2, 3, 4: return 31'($urandom_range(0, 7));
            default: return 31'($urandom);
        endcase
    endfunction

    // One graph: rows 0..g, all objectives of each edge, noise, starts and queries.
    task automatic run_phase(int cnt, int obj, int g);
        int edges;
        int t;
        int src;
        int n_eff;
        int starts;
        wait_idle();
        write_reg(csrdsp_pkg::CFG_NODE_COUNT, cnt[10:0]);
        write_reg(csrdsp_pkg::CFG_OBJECTIVE, obj[10:0]);
        n_eff = (cnt > NODES_MAX) ? NODES_MAX : cnt;
        edges = $urandom_range(0, 3 * g);
        if (edges > edge_top)
            edge_top = edges;
        for (int i = 0; i <= g; i++)
        begin
            add_beat(csrdsp_pkg::REQ_ROW, i, $urandom_range(0, edges), $urandom,
                     31'($urandom), $urandom, $urandom);
            row_written[i] = 1'b1;
        end
        for (int e = 0; e < edges; e++)
        begin
            t = $urandom_range(0, g - 1);
            if ($urandom_range(0, 5) == 0)
            begin
                src = $urandom_range(0, NODES_MAX - 1);
                if (row_written[src] && row_written[src + 1])
                    t = src;
            end
            for (int o = 0; o < OBJ_NUM; o++)
                add_beat(csrdsp_pkg::REQ_EDGE, e, $urandom, t, pick_weight(), o, $urandom);
        end
        if ($urandom_range(0, 1) == 0)
            add_beat(csrdsp_pkg::REQ_ROW, $urandom_range(NODES_MAX + 1, 8191),
                     $urandom_range(0, 8191), $urandom, 31'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 1) == 0)
            add_beat(csrdsp_pkg::REQ_EDGE, $urandom_range(EDGES_MAX, 8191), $urandom,
                     $urandom, 31'($urandom), $urandom, $urandom);
        starts = $urandom_range(1, 2);
        for (int s = 0; s < starts; s++)
        begin
            src = $urandom_range(0, g - 1);
            if ($urandom_range(0, 3) == 0)
            begin
                t = $urandom_range(0, NODES_MAX - 1);
                if (t >= n_eff || (row_written[t] && row_written[t + 1]))
                    src = t;
            end
            add_beat(csrdsp_pkg::REQ_START, $urandom, $urandom, $urandom, 31'($urandom),
                     $urandom, src);
            for (int q = 0; q <= g + 1; q++)
                add_beat(csrdsp_pkg::REQ_QUERY, q, $urandom, $urandom, 31'($urandom),
                         $urandom, $urandom);
            for (int q = 0; q < 3; q++)
                add_beat(csrdsp_pkg::REQ_QUERY, $urandom_range(0, 8191), $urandom, $urandom,
                         31'($urandom), $urandom, $urandom);
        end
    endtask

    initial
    begin
        int cnt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        item_total = 0;
        edge_top = 0;
        node_cnt_reg = 11'd1;
        obj_sel_reg = 2'd0;
        frontier_fill = 0;
        for (int i = 0; i < NODES_MAX; i++)
        begin
            best_dist[i] = DIST_INF[48:0];
            tree_par[i] = -1;
        end
        for (int i = 0; i <= NODES_MAX; i++)
            row_written[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset count with queries, then extremes of the count and objective
        add_beat(csrdsp_pkg::REQ_ROW, 0, 0, 0, '0, 0, 0);
        add_beat(csrdsp_pkg::REQ_ROW, 1, 0, 0, '0, 0, 0);
        row_written[0] = 1'b1;
        row_written[1] = 1'b1;
        add_beat(csrdsp_pkg::REQ_START, 0, 0, 0, '0, 0, 0);
        add_beat(csrdsp_pkg::REQ_QUERY, 0, 0, 0, '0, 0, 0);
        add_beat(csrdsp_pkg::REQ_QUERY, 8191, 8191, 1023, 31'h7FFF_FFFF, 3, 1023);
        add_beat(csrdsp_pkg::REQ_START, 8191, 8191, 1023, 31'h7FFF_FFFF, 3, 1023);
        run_phase(0, 1, 2);
        run_phase(2047, 3, 6);
        run_phase(1024, 2, 4);
        run_phase(1, 0, 2);

        while (item_total < 1650)
        begin
            case ($urandom_range(0, 5))
                0: cnt = 0;
                1: cnt = 1024;
                2: cnt = 2047;
                3: cnt = $urandom_range(1, 1024);
                default: cnt = $urandom_range(1, 14);
            endcase
            run_phase(cnt, $urandom_range(0, 3), $urandom_range(2, 10));
        end
        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/csrdsp_pkg.sv
sv/csr_dijkstra_shortest_path_core.sv
test/tb_top.sv
